@@ rtl/firconv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the full-convolution FIR block.
// No dependencies; every other SystemVerilog file relies on this package.
package firconv_pkg;

  localparam int TAPS      = 32;
  localparam int MAX_OUT   = 32;
  localparam int TAP_LIMIT = (TAPS < MAX_OUT) ? TAPS : MAX_OUT;

  localparam int SAMPLE_W = 16;
  localparam int IN_IDX_W = 5;
  localparam int TC_W     = 6;
  localparam int OUT_W    = 37;
  localparam int PROD_W   = 2 * SAMPLE_W;

  localparam int LEVELS = $clog2(TAPS);
  localparam int NP     = 1 << LEVELS;
  localparam int ACC_W  = (PROD_W + LEVELS > OUT_W) ? PROD_W + LEVELS : OUT_W;
  localparam int LANE_W = $clog2(TAPS);
  localparam int EFF_W  = $clog2(TAP_LIMIT + 1);

  // delay line stage, product stage, one stage per tree level
  localparam int NS = LEVELS + 2;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic              shift;
    logic              zero;
    logic              clear;
    logic              coef_we;
    logic [LANE_W-1:0] coef_idx;
    logic [EFF_W-1:0]  taps;
  } line_ctrl_t;

endpackage

@@ rtl/firconv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for input items and result items.
// Depends on firconv_pkg for field widths.
interface firconv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic [firconv_pkg::IN_IDX_W-1:0]        tap_index;
  logic signed [firconv_pkg::SAMPLE_W-1:0] value;
  logic                                    block_end;

  modport source (output valid, kind, tap_index, value, block_end, input ready);
  modport sink (input valid, kind, tap_index, value, block_end, output ready);
endinterface

interface firconv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [firconv_pkg::OUT_W-1:0] filtered;
  logic                                 final_res;

  modport source (output valid, filtered, final_res, input ready);
  modport sink (input valid, filtered, final_res, output ready);
endinterface

@@ rtl/firconv_taps.sv @@
`timescale 1ns / 1ps
// Delay line, coefficient registers and the per-lane product registers.
// Depends on firconv_pkg.
module firconv_taps (
  input  logic                                    clk,
  input  logic                                    rst,
  input  firconv_pkg::line_ctrl_t                 ctrl,
  input  logic signed [firconv_pkg::SAMPLE_W-1:0] value,
  input  logic                                    prod_en,
  output logic signed [firconv_pkg::ACC_W-1:0]    leaf [firconv_pkg::NP]
);
  import firconv_pkg::*;

  logic signed [SAMPLE_W-1:0] coef [TAPS];
  logic signed [SAMPLE_W-1:0] dl [TAPS];
  logic                       clr_pend;

  always_ff @(posedge clk) begin
    if (ctrl.coef_we) begin
      coef[ctrl.coef_idx] <= value;
    end
  end

  // A finished block leaves clr_pend set; the old contents are dropped on
  // the next shift instead of right away, so the final tail sum still sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_pend <= 1'b0;
      for (int k = 0; k < TAPS; k++) begin
        dl[k] <= '0;
      end
    end else if (ctrl.shift) begin
      clr_pend <= ctrl.clear;
      dl[0]    <= ctrl.zero ? '0 : value;
      for (int k = 1; k < TAPS; k++) begin
        dl[k] <= clr_pend ? '0 : dl[k-1];
      end
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_lane
    if (k < TAP_LIMIT) begin : g_act
      logic lane_on;
      assign lane_on = ctrl.taps > EFF_W'(k);
      always_ff @(posedge clk) begin
        if (prod_en) begin
          leaf[k] <= lane_on ? ACC_W'(coef[k] * dl[k]) : '0;
        end
      end
    end else begin : g_off
      always_ff @(posedge clk) begin
        if (prod_en) begin
          leaf[k] <= '0;
        end
      end
    end
  end

endmodule

@@ rtl/firconv_tree.sv @@
`timescale 1ns / 1ps
// Registered binary adder tree, one register level per tree level.
// Depends on firconv_pkg.
module firconv_tree (
  input  logic                                 clk,
  input  logic [firconv_pkg::LEVELS-1:0]       node_en,
  input  logic signed [firconv_pkg::ACC_W-1:0] leaf [firconv_pkg::NP],
  output logic signed [firconv_pkg::OUT_W-1:0] sum
);
  import firconv_pkg::*;

  // heap order: node i has children 2i+1 and 2i+2, leaves at NP-1 and up
  logic signed [ACC_W-1:0] node_q [NP-1];
  logic signed [ACC_W-1:0] all_n [2*NP-1];

  for (genvar i = 0; i < NP - 1; i++) begin : g_node
    localparam int D = $clog2(i + 2) - 1;
    assign all_n[i] = node_q[i];
    always_ff @(posedge clk) begin
      if (node_en[D]) begin
        node_q[i] <= all_n[2*i+1] + all_n[2*i+2];
      end
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_leaf
    assign all_n[NP-1+k] = leaf[k];
  end

  // wraps to the output width
  assign sum = node_q[0][OUT_W-1:0];

endmodule

@@ rtl/fir_full_convolution.sv @@
`timescale 1ns / 1ps
// FIR full linear convolution, direct form with a registered adder tree.
// Depends on firconv_pkg, firconv_if, firconv_taps and firconv_tree.
//
// One input item is taken per clock while din.ready is high: a coefficient
// load (kind 0) or a sample (kind 1). Each sample gives one full-precision
// sum of products through the delay line register, the product register and
// one register per adder tree level. A sample marked block_end holds off the
// input while taps-1 zeros shift in to produce the tail, taps being tap_count
// limited to 1..32; the last tail result carries final_res. Pipeline stages
// advance independently, so bubbles close up while a result waits on the
// output. The user must write tap_count only while the block is idle; the
// block itself does not enforce it. There is no clearing pass after reset.
module fir_full_convolution (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [firconv_pkg::TC_W-1:0] cfg_wdata,
  firconv_in_if.sink                   din,
  firconv_out_if.source                dout
);
  import firconv_pkg::*;

  logic [TC_W-1:0]        tap_count;
  logic [EFF_W-1:0]       eff;
  logic                   flushing;
  logic [EFF_W-1:0]       remaining;
  logic [NS-1:0]          v;
  logic [NS-1:0]          fin;
  logic [NS-1:0]          en;
  logic [LEVELS-1:0]      node_en;
  logic                   accept;
  logic                   smp_acc;
  logic                   last_step;
  line_ctrl_t             ctrl;
  logic signed [ACC_W-1:0] leaf [NP];

  always_comb begin
    if (tap_count == '0) begin
      eff = EFF_W'(1);
    end else if (32'(tap_count) > TAP_LIMIT) begin
      eff = EFF_W'(TAP_LIMIT);
    end else begin
      eff = EFF_W'(tap_count);
    end
  end

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !v[NS-1] || dout.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
    for (int d = 0; d < LEVELS; d++) begin
      node_en[d] = en[LEVELS-d+1];
    end
  end

  assign din.ready = en[0] && !flushing;
  assign accept    = din.valid && din.ready;
  assign smp_acc   = accept && din.kind == KIND_SAMPLE;
  assign last_step = flushing ? (remaining == EFF_W'(1))
                              : (din.block_end && eff == EFF_W'(1));

  always_comb begin
    ctrl.shift    = smp_acc || (flushing && en[0]);
    ctrl.zero     = flushing;
    ctrl.clear    = last_step;
    ctrl.coef_we  = accept && din.kind == KIND_COEF && 32'(din.tap_index) < TAPS;
    ctrl.coef_idx = LANE_W'(din.tap_index);
    ctrl.taps     = eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TC_W'(32);
      flushing  <= 1'b0;
      remaining <= '0;
      v         <= '0;
      fin       <= '0;
    end else begin
      if (cfg_we) begin
        tap_count <= cfg_wdata;
      end
      if (smp_acc && din.block_end && eff != EFF_W'(1)) begin
        flushing  <= 1'b1;
        remaining <= eff - EFF_W'(1);
      end else if (flushing && en[0]) begin
        remaining <= remaining - EFF_W'(1);
        if (remaining == EFF_W'(1)) begin
          flushing <= 1'b0;
        end
      end
      if (en[0]) begin
        v[0]   <= ctrl.shift;
        fin[0] <= ctrl.shift && last_step;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v[s]   <= v[s-1];
          fin[s] <= fin[s-1];
        end
      end
    end
  end

  firconv_taps u_taps (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .value   (din.value),
    .prod_en (en[1]),
    .leaf    (leaf)
  );

  firconv_tree u_tree (
    .clk     (clk),
    .node_en (node_en),
    .leaf    (leaf),
    .sum     (dout.filtered)
  );

  assign dout.valid     = v[NS-1];
  assign dout.final_res = fin[NS-1];

endmodule

@@ verif/tb_fir_full_convolution.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fir_full_convolution: directed and random items,
// with an in-order predictor of the convolution sums and block-end tails.
// Depends on firconv_pkg, firconv_if and the fir_full_convolution RTL.
module tb_fir_full_convolution;
  import firconv_pkg::*;

  localparam int DRAIN_CYCLES = 2 * NS + 6;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 62;

  typedef struct {
    logic signed [OUT_W-1:0] filtered;
    logic                    final_res;
  } conv_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TC_W-1:0]   cfg_wdata;

  firconv_in_if  sample_ch ();
  firconv_out_if result_ch ();

  fir_full_convolution u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (sample_ch),
    .dout      (result_ch)
  );

  // predictor state
  logic signed [SAMPLE_W-1:0] line_model [TAPS];
  logic signed [SAMPLE_W-1:0] coef_model [TAPS];
  logic [TC_W-1:0]            taps_model;
  conv_result_t               pending_sums [$];

  int  errors;
  bit  no_idle;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // shift one sample into the delay line and form the sum over n taps
  function automatic logic signed [OUT_W-1:0] shift_in_mac(logic signed [SAMPLE_W-1:0] s,
                                                           int n);
    longint acc;
    int k;
    acc = 0;
    for (k = TAPS - 1; k > 0; k--) line_model[k] = line_model[k-1];
    line_model[0] = s;
    for (k = 0; k < n; k++) acc += longint'(coef_model[k]) * longint'(line_model[k]);
    return acc[OUT_W-1:0];
  endfunction

  function automatic void convolve_item(logic kind, logic [IN_IDX_W-1:0] idx,
                                        logic signed [SAMPLE_W-1:0] val, logic last);
    int n;
    int k;
    conv_result_t r;
    if (kind == KIND_COEF) begin
      if (int'(idx) < TAPS) coef_model[idx] = val;
      return;
    end
    n = int'(taps_model);
    if (n < 1) n = 1;
    if (n > TAP_LIMIT) n = TAP_LIMIT;
    r.filtered  = shift_in_mac(val, n);
    r.final_res = last && (n == 1);
    pending_sums.push_back(r);
    if (!last) return;
    // tail: zeros flush out the remaining taps
    for (k = 1; k < n; k++) begin
      r.filtered  = shift_in_mac('0, n);
      r.final_res = (k == n - 1);
      pending_sums.push_back(r);
    end
    for (k = 0; k < TAPS; k++) line_model[k] = '0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic drive_item(logic kind, logic [IN_IDX_W-1:0] idx,
                            logic signed [SAMPLE_W-1:0] val, logic last);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.kind      = kind;
    sample_ch.tap_index = idx;
    sample_ch.value     = val;
    sample_ch.block_end = last;
    sample_ch.valid     = 1'b1;
    forever begin
      @(posedge clk);
      if (sample_ch.ready === 1'b1) break;
      @(negedge clk);
    end
    convolve_item(kind, idx, val, last);
  endtask

  task automatic load_coef(int idx, logic signed [SAMPLE_W-1:0] val, logic last = 1'b0);
    drive_item(KIND_COEF, IN_IDX_W'(idx), val, last);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] val, logic last);
    drive_item(KIND_SAMPLE, '0, val, last);
  endtask

  // register writes only with the pipeline empty
  task automatic set_tap_count(logic [TC_W-1:0] v);
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we     = 1'b0;
    taps_model = v;
  endtask

  task automatic test_small_taps();
    set_tap_count(6'd3);
    load_coef(0, -16'sd32768);
    load_coef(1, 16'sd32767, 1'b1);  // block_end on a load has no effect
    load_coef(2, 16'sd1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    load_coef(1, -16'sd2);           // coefficient change mid-block
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd32768, 1'b1);
  endtask

  task automatic test_single_tap();
    set_tap_count(6'd0);             // zero acts as one tap
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd1, 1'b1);
    set_tap_count(6'd1);
    send_sample(16'sd32767, 1'b1);
  endtask

  // every tap at the negative extreme: largest positive sum
  task automatic test_full_scale();
    int k;
    no_idle = 1'b1;
    set_tap_count(6'd32);
    for (k = 0; k < TAPS; k++) load_coef(k, -16'sd32768);
    for (k = 0; k < TAPS; k++) send_sample(-16'sd32768, k == TAPS - 1);
    no_idle = 1'b0;
    for (k = 0; k < TAPS; k++) load_coef(k, rand_value());
  endtask

  task automatic test_random_phases();
    logic [TC_W-1:0] settings [5];
    int p;
    int i;
    settings[0] = 6'd63;
    settings[1] = 6'd33;
    settings[2] = TC_W'($urandom_range(2, 31));
    settings[3] = 6'd2;
    settings[4] = 6'd32;
    for (p = 0; p < 5; p++) begin
      set_tap_count(settings[p]);
      no_idle = (p == 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 6) == 0)
          load_coef(int'($urandom_range(0, TAPS - 1)), rand_value(), 1'($urandom));
        else
          send_sample(rand_value(), $urandom_range(0, 9) == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  // result side: random stalls, compare each transfer with the oldest sum
  initial begin : result_checker
    int stall;
    conv_result_t want;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result filtered=%0d final_res=%b",
                                  result_ch.filtered, result_ch.final_res));
      end else begin
        want = pending_sums.pop_front();
        if (result_ch.filtered !== want.filtered)
          report_mismatch($sformatf("filtered %0d, expected %0d",
                                    result_ch.filtered, want.filtered));
        if (result_ch.final_res !== want.final_res)
          report_mismatch($sformatf("final_res %b, expected %b",
                                    result_ch.final_res, want.final_res));
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    errors              = 0;
    no_idle             = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.kind      = KIND_COEF;
    sample_ch.tap_index = '0;
    sample_ch.value     = '0;
    sample_ch.block_end = 1'b0;
    taps_model          = 6'd32;
    for (k = 0; k < TAPS; k++) begin
      line_model[k] = '0;
      coef_model[k] = '0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_small_taps();
    test_single_tap();
    test_full_scale();
    test_random_phases();

    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/firconv_pkg.sv
rtl/firconv_if.sv
rtl/firconv_taps.sv
rtl/firconv_tree.sv
rtl/fir_full_convolution.sv
verif/tb_fir_full_convolution.sv
